/* src/x86_arith_flags_unit_assert.svh */
// Assertion macros for the x86 flag unit.
// Define NO_ASSERTIONS to compile every check away.
`ifndef X86_ARITH_FLAGS_UNIT_ASSERT_SVH
`define X86_ARITH_FLAGS_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check on every clock edge outside reset.
`define X86AF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define X86AF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define X86AF_ASSERT(label, prop, msg)
`define X86AF_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* src/x86af_pkg.sv */
`default_nettype none

package x86af_pkg;

  // Operation kinds
  localparam logic [3:0] KIND_ADD      = 4'd0;
  localparam logic [3:0] KIND_SUB      = 4'd1;
  localparam logic [3:0] KIND_LOGIC    = 4'd2;
  localparam logic [3:0] KIND_INC      = 4'd3;
  localparam logic [3:0] KIND_DEC      = 4'd4;
  localparam logic [3:0] KIND_SHL      = 4'd5;
  localparam logic [3:0] KIND_SHR      = 4'd6;
  localparam logic [3:0] KIND_SAR      = 4'd7;
  localparam logic [3:0] KIND_EXPLICIT = 4'd8;

  // Operand size codes
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_DWORD = 2'd2;

  // Status word bit positions
  localparam int FLAG_CF    = 0;
  localparam int FLAG_FIXED = 1;
  localparam int FLAG_PF    = 2;
  localparam int FLAG_AF    = 4;
  localparam int FLAG_ZF    = 6;
  localparam int FLAG_SF    = 7;
  localparam int FLAG_OF    = 11;

  localparam int FLAGS_W = 12;

  localparam logic [FLAGS_W-1:0] STATUS_MASK = 12'h8D5;

  // Result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef logic [FLAGS_W-1:0] flags_t;

endpackage

`default_nettype wire

/* src/x86_arith_flags_unit.sv */
`default_nettype none

// x86 status flag unit. Each input word describes one finished ALU operation
// (kind, operands, result, operand size) and yields one output word holding
// the low twelve EFLAGS bits (CF, fixed one, PF, AF, ZF, SF, OF) plus a status
// bit. CF of each recorded operation is kept so that INC and DEC can pass it
// on; an explicit flags load sets it from bit 0 of operand_a. A shift by zero,
// an unknown kind or size code three (other than for an explicit load) is
// rejected: status is one, flags_word is zero and the held carry stays.
// Timing: an input register feeds one level of flag logic into the output
// register, so a word passes two register stages, and out_valid rises when
// the word moves from the input register into the output register. The unit
// takes a new word every cycle while the output side keeps up. The held
// carry is updated as a word moves from the input register to the output
// register, so consecutive INC/DEC words see the carry of the word right
// before them with no bubble.

`include "x86_arith_flags_unit_assert.svh"

module x86_arith_flags_unit
  import x86af_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  kind,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  input  wire logic [31:0] result_value,
  input  wire logic [1:0]  width_code,

  output logic             out_valid,
  input  wire logic        out_ready,
  output flags_t           flags_word,
  output logic             status
);

  // Input register
  logic        stage_valid;
  logic [3:0]  stage_kind;
  logic [31:0] stage_a;
  logic [31:0] stage_b;
  logic [31:0] stage_r;
  logic [1:0]  stage_width;

  // Carry of the last recorded operation
  logic        held_carry;

  logic        out_free;
  logic        advance;

  // Flag logic
  logic [5:0]  bits;
  logic [4:0]  sign_idx;
  logic [31:0] mask;
  logic [31:0] top;
  logic [31:0] am;
  logic [31:0] bm;
  logic [31:0] rm;
  logic        sa;
  logic        sb;
  logic        sr;
  logic        is_shift;
  logic        count_big;
  logic [4:0]  shl_pos;
  logic [4:0]  shr_pos;
  logic        cf;
  logic        of;
  logic        af;
  logic        reject;
  flags_t      flags_next;
  logic        status_next;
  logic        held_carry_next;

  assign out_free = !out_valid || out_ready;
  assign advance  = stage_valid && out_free;
  assign in_ready = !stage_valid || out_free;

  // Accept into the input register whenever it empties or drains this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_kind  <= kind;
      stage_a     <= operand_a;
      stage_b     <= operand_b;
      stage_r     <= result_value;
      stage_width <= width_code;
    end
  end

  always_comb begin
    case (stage_width)
      SIZE_BYTE: begin
        bits = 6'd8;
        mask = 32'h0000_00FF;
      end
      SIZE_WORD: begin
        bits = 6'd16;
        mask = 32'h0000_FFFF;
      end
      default: begin
        bits = 6'd32;
        mask = 32'hFFFF_FFFF;
      end
    endcase
    sign_idx = 5'(bits - 6'd1);
    top      = mask ^ (mask >> 1);

    am = stage_a & mask;
    bm = stage_b & mask;
    rm = stage_r & mask;
    sa = stage_a[sign_idx];
    sb = stage_b[sign_idx];
    sr = stage_r[sign_idx];

    is_shift  = (stage_kind == KIND_SHL) || (stage_kind == KIND_SHR) ||
                (stage_kind == KIND_SAR);
    count_big = stage_b > {26'd0, bits};
    // Only meaningful when the count is within the operand size.
    shl_pos   = 5'(bits - stage_b[5:0]);
    shr_pos   = 5'(stage_b[5:0] - 6'd1);

    cf = 1'b0;
    of = 1'b0;
    af = 1'b0;
    case (stage_kind)
      KIND_ADD: begin
        cf = rm < am;
        of = (sa == sb) && (sr != sa);
        af = stage_a[4] ^ stage_b[4] ^ stage_r[4];
      end
      KIND_SUB: begin
        cf = am < bm;
        of = (sa != sb) && (sr != sa);
        af = stage_a[4] ^ stage_b[4] ^ stage_r[4];
      end
      KIND_INC: begin
        cf = held_carry;
        of = rm == top;
        af = stage_a[4] ^ stage_b[4] ^ stage_r[4];
      end
      KIND_DEC: begin
        cf = held_carry;
        of = am == top;
        af = stage_a[4] ^ stage_b[4] ^ stage_r[4];
      end
      KIND_SHL: begin
        af = 1'b1;
        cf = count_big ? 1'b0 : stage_a[shl_pos];
        of = sr ^ cf;
      end
      KIND_SHR: begin
        af = 1'b1;
        cf = count_big ? 1'b0 : stage_a[shr_pos];
        of = (stage_b == 32'd1) ? sa : 1'b0;
      end
      KIND_SAR: begin
        af = 1'b1;
        cf = count_big ? sa : stage_a[shr_pos];
      end
      default: begin
        // logic ops and anything else leave CF, AF, OF clear
      end
    endcase

    reject = (stage_kind > KIND_EXPLICIT) ||
             ((stage_kind != KIND_EXPLICIT) && (stage_width == 2'd3)) ||
             (is_shift && (stage_b == 32'd0));

    flags_next = '0;
    flags_next[FLAG_FIXED] = 1'b1;
    if (stage_kind == KIND_EXPLICIT) begin
      flags_next      = (stage_a[FLAGS_W-1:0] & STATUS_MASK);
      flags_next[FLAG_FIXED] = 1'b1;
      status_next     = STATUS_OK;
      held_carry_next = stage_a[0];
    end else if (reject) begin
      flags_next      = '0;
      status_next     = STATUS_REJECTED;
      held_carry_next = held_carry;
    end else begin
      flags_next[FLAG_CF] = cf;
      flags_next[FLAG_PF] = ~^stage_r[7:0];
      flags_next[FLAG_AF] = af;
      flags_next[FLAG_ZF] = rm == 32'd0;
      flags_next[FLAG_SF] = sr;
      flags_next[FLAG_OF] = of;
      status_next         = STATUS_OK;
      held_carry_next     = cf;
    end
  end

  // Output register; hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      held_carry <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= stage_valid;
      end
      if (advance) begin
        held_carry <= held_carry_next;
      end
    end
    if (advance) begin
      flags_word <= flags_next;
      status     <= status_next;
    end
  end

  `X86AF_ASSERT_ALWAYS(a_reset_empties, rst |=> (!stage_valid && !out_valid), "pipeline not empty after reset")
  `X86AF_ASSERT(a_carry_stable, !advance |=> $stable(held_carry), "held carry moved without a word")
  `X86AF_ASSERT(a_carry_matches, advance |=> (status || (held_carry == flags_word[FLAG_CF])), "held carry differs from delivered CF")
  `X86AF_ASSERT(a_fixed_bit, (out_valid && !status) |-> flags_word[FLAG_FIXED], "fixed flag bit clear on a recorded word")

endmodule

`default_nettype wire

/* sim/x86_arith_flags_unit_tb.sv */
`timescale 1ns / 100ps

module x86_arith_flags_unit_tb;
  import x86af_pkg::*;

  // Cycles with no word moving on either side before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Cycles to wait past the last result so that a stray extra word shows up.
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_WORDS = 450;

  typedef struct packed {
    flags_t flags;
    logic   status;
  } flag_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  kind;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic [31:0] result_value;
  logic [1:0]  width_code;
  logic        out_valid;
  logic        out_ready;
  flags_t      flags_word;
  logic        status;

  // Predictor state: CF of the last recorded operation, as INC and DEC see it.
  logic carry_state;
  // Flags predicted for accepted words, oldest first.
  flag_result_t pending_flags[$];
  int unsigned error_count;
  int unsigned quiet_cycles;
  // Set while both sides run without idle cycles.
  bit no_idle;

  x86_arith_flags_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .result_value (result_value),
    .width_code   (width_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .flags_word   (flags_word),
    .status       (status)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Operand size in bits; size code three has no size and is rejected anyway.
  function automatic int unsigned size_bits(input logic [1:0] wc);
    case (wc)
      SIZE_BYTE: return 8;
      SIZE_WORD: return 16;
      default:   return 32;
    endcase
  endfunction

  function automatic logic [31:0] size_mask(input logic [1:0] wc);
    case (wc)
      SIZE_BYTE: return 32'h0000_00FF;
      SIZE_WORD: return 32'h0000_FFFF;
      default:   return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Predict the status word for one accepted word and advance the carry state.
  function automatic flag_result_t eval_flags(input logic [3:0] k, input logic [31:0] a,
                                              input logic [31:0] b, input logic [31:0] r,
                                              input logic [1:0] wc);
    flag_result_t res;
    int unsigned  bits;
    logic [31:0]  m;
    logic [31:0]  top;
    logic         sa, sb, sr, cf, of, af;
    logic         shift_kind;
    res.flags  = '0;
    res.status = STATUS_OK;
    shift_kind = (k == KIND_SHL) || (k == KIND_SHR) || (k == KIND_SAR);
    // Explicit load: copy the status bits, force the fixed bit, take CF as carry.
    if (k == KIND_EXPLICIT) begin
      res.flags = (a[FLAGS_W-1:0] & STATUS_MASK);
      res.flags[FLAG_FIXED] = 1'b1;
      carry_state = a[0];
      return res;
    end
    // Unknown kind, size code three or a shift by zero: reject, keep the carry.
    if (k > KIND_EXPLICIT || wc > SIZE_DWORD || (shift_kind && b == 32'd0)) begin
      res.status = STATUS_REJECTED;
      return res;
    end
    bits = size_bits(wc);
    m    = size_mask(wc);
    top  = 32'd1 << (bits - 1);
    sa   = a[bits-1];
    sb   = b[bits-1];
    sr   = r[bits-1];
    cf   = 1'b0;
    of   = 1'b0;
    af   = a[4] ^ b[4] ^ r[4];
    case (k)
      KIND_ADD: begin
        cf = (r & m) < (a & m);
        of = (sa == sb) && (sr != sa);
      end
      KIND_SUB: begin
        cf = (a & m) < (b & m);
        of = (sa != sb) && (sr != sa);
      end
      KIND_INC: begin
        cf = carry_state;
        of = (r & m) == top;
      end
      KIND_DEC: begin
        cf = carry_state;
        of = (a & m) == top;
      end
      KIND_LOGIC: begin
        af = 1'b0;
      end
      default: begin
        af = 1'b1;
        // A count past the operand size shifts everything out.
        if (b > bits) begin
          cf = (k == KIND_SAR) ? sa : 1'b0;
        end else if (k == KIND_SHL) begin
          cf = a[bits - b];
        end else begin
          cf = a[b - 1];
        end
        if (k == KIND_SHL) begin
          of = sr ^ cf;
        end else if (k == KIND_SHR) begin
          of = (b == 32'd1) ? sa : 1'b0;
        end
      end
    endcase
    res.flags[FLAG_CF]    = cf;
    res.flags[FLAG_FIXED] = 1'b1;
    res.flags[FLAG_PF]    = ~^r[7:0];
    res.flags[FLAG_AF]    = af;
    res.flags[FLAG_ZF]    = (r & m) == 32'd0;
    res.flags[FLAG_SF]    = sr;
    res.flags[FLAG_OF]    = of;
    carry_state = cf;
    return res;
  endfunction

  // Result that a real ALU leaves for the operation, cut to the operand size.
  function automatic logic [31:0] alu_result(input logic [3:0] k, input logic [31:0] a,
                                             input logic [31:0] b, input logic [1:0] wc);
    logic [31:0]        m;
    logic signed [31:0] sx;
    m = size_mask(wc);
    case (wc)
      SIZE_BYTE: sx = {{24{a[7]}}, a[7:0]};
      SIZE_WORD: sx = {{16{a[15]}}, a[15:0]};
      default:   sx = a;
    endcase
    case (k)
      KIND_ADD:   return (a + b) & m;
      KIND_SUB:   return (a - b) & m;
      KIND_INC:   return (a + 32'd1) & m;
      KIND_DEC:   return (a - 32'd1) & m;
      KIND_LOGIC: begin
        case ($urandom_range(2))
          0:       return (a & b) & m;
          1:       return (a | b) & m;
          default: return (a ^ b) & m;
        endcase
      end
      KIND_SHL:   return (a << b) & m;
      KIND_SHR:   return ((a & m) >> b) & m;
      KIND_SAR:   return (sx >>> ((b > 32'd31) ? 32'd31 : b)) & m;
      default:    return $urandom;
    endcase
  endfunction

  // Operand biased toward the edges of the signed and unsigned range.
  function automatic logic [31:0] pick_operand(input logic [1:0] wc);
    logic [31:0] m;
    m = size_mask(wc);
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return m;
      2:       return (m >> 1) + 32'd1;
      3:       return m >> 1;
      4:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word, hold it until accepted and queue its predicted flags.
  task automatic send_op(input logic [3:0] k, input logic [31:0] a, input logic [31:0] b,
                         input logic [31:0] r, input logic [1:0] wc);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    kind         = k;
    operand_a    = a;
    operand_b    = b;
    result_value = r;
    width_code   = wc;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_flags.push_back(eval_flags(k, a, b, r, wc));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Send an operation with the result it really produces.
  task automatic send_alu(input logic [3:0] k, input logic [31:0] a, input logic [31:0] b,
                          input logic [1:0] wc);
    send_op(k, a, b, alu_result(k, a, b, wc), wc);
  endtask

  task automatic test_add_sub_edges();
    send_alu(KIND_ADD, 32'h0000_00FF, 32'h0000_0001, SIZE_BYTE);   // carry out, zero
    send_alu(KIND_ADD, 32'h0000_007F, 32'h0000_0001, SIZE_BYTE);   // signed overflow
    send_alu(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_DWORD);
    send_alu(KIND_INC, 32'h0000_007F, 32'h0000_0001, SIZE_BYTE);   // keeps CF of the add
    send_alu(KIND_SUB, 32'h0000_0000, 32'h0000_0001, SIZE_WORD);   // borrow
    send_alu(KIND_SUB, 32'h8000_0000, 32'h0000_0001, SIZE_DWORD);  // signed overflow
    send_alu(KIND_DEC, 32'h8000_0000, 32'h0000_0001, SIZE_DWORD);  // most negative operand
    send_op(KIND_LOGIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_DWORD);
  endtask

  task automatic test_explicit_and_carry();
    send_op(KIND_EXPLICIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_DWORD);
    send_alu(KIND_INC, 32'h0000_FFFF, 32'h0000_0001, SIZE_WORD);   // wraps, CF from load
    send_op(KIND_EXPLICIT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, SIZE_BYTE);
    send_alu(KIND_DEC, 32'h0000_0000, 32'h0000_0001, SIZE_BYTE);
    // Size code three does not matter for a load.
    send_op(KIND_EXPLICIT, 32'h0000_08D5, 32'h0, 32'h0, 2'd3);
  endtask

  task automatic test_shift_edges();
    send_alu(KIND_SHL, 32'h0000_0081, 32'd1, SIZE_BYTE);
    send_alu(KIND_SHL, 32'h0000_0001, 32'd8, SIZE_BYTE);           // count equal to size
    send_alu(KIND_SHL, 32'h0000_00FF, 32'd9, SIZE_BYTE);           // count past size
    send_alu(KIND_SHR, 32'h0000_8000, 32'd1, SIZE_WORD);
    send_alu(KIND_SHR, 32'h8000_0001, 32'd32, SIZE_DWORD);
    send_alu(KIND_SAR, 32'h0000_0080, 32'd9, SIZE_BYTE);
    send_alu(KIND_SAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_DWORD);
  endtask

  task automatic test_rejects();
    send_op(KIND_SHL, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, SIZE_DWORD);  // shift by zero
    send_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_DWORD);
    send_op(4'd9, 32'h1234_5678, 32'h0, 32'h0, 2'd3);
    send_op(KIND_ADD, 32'h0000_00FF, 32'h1, 32'h0, 2'd3);
    send_op(KIND_SHR, 32'h0000_00FF, 32'h1, 32'h7F, 2'd3);
    // Carry must have survived the rejects.
    send_alu(KIND_INC, 32'h0000_0010, 32'h1, SIZE_BYTE);
  endtask

  task automatic test_random_ops();
    logic [3:0]  k;
    logic [1:0]  wc;
    logic [31:0] a, b, r;
    int unsigned roll;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      no_idle = (i >= 150) && (i < 250);
      roll = $urandom_range(99);
      if (roll < 8) begin
        // Noise: any kind, any size code, unrelated result.
        k  = 4'($urandom_range(15));
        wc = 2'($urandom_range(3));
        a  = $urandom;
        b  = $urandom;
        r  = $urandom;
      end else begin
        k  = 4'($urandom_range(8));
        wc = 2'($urandom_range(2));
        a  = pick_operand(wc);
        b  = pick_operand(wc);
        if (k == KIND_INC || k == KIND_DEC) begin
          if ($urandom_range(3) != 0) b = 32'd1;
        end else if (k == KIND_SHL || k == KIND_SHR || k == KIND_SAR) begin
          roll = $urandom_range(99);
          if (roll < 70)      b = $urandom_range(size_bits(wc) + 2, 1);
          else if (roll < 78) b = 32'd0;
          else                b = $urandom;
        end
        r = ($urandom_range(9) == 0) ? $urandom : alu_result(k, a, b, wc);
      end
      send_op(k, a, b, r, wc);
    end
    no_idle = 1'b0;
  endtask

  // Stall the result side at random, except in the idle-free stretch.
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 31);
  end

  // Compare each returned word with the oldest prediction.
  always @(posedge clk) begin
    flag_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_flags.size() == 0) begin
        $display("%0t: unexpected word, flags_word %h status %b", $time, flags_word, status);
        error_count++;
      end else begin
        want = pending_flags.pop_front();
        if (flags_word !== want.flags) begin
          $display("%0t: flags_word expected %h actual %h", $time, want.flags, flags_word);
          error_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, status);
          error_count++;
        end
      end
    end
  end

  // Abandon the run when no word moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = '0;
    operand_a    = '0;
    operand_b    = '0;
    result_value = '0;
    width_code   = '0;
    out_ready    = 1'b0;
    carry_state  = 1'b0;
    error_count  = 0;
    no_idle      = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_add_sub_edges();
    test_explicit_and_carry();
    test_shift_edges();
    test_rejects();
    test_random_ops();

    // Drain: the watchdog covers a missing word.
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/x86af_pkg.sv
src/x86_arith_flags_unit.sv
sim/x86_arith_flags_unit_tb.sv
